>>> hdl/tqbs_pkg.sv
// Shared constants and helpers for the textured quad batch setup block.
`timescale 1ns / 1ps
package tqbs_pkg;

   localparam int SLOTS_DEF       = 6;
   localparam int VCAP_DEF        = 4096;
   localparam int VERTS_PER_QUAD  = 6;
   localparam int UV_W            = 16;
   localparam int CSR_IDX_W       = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_M_XX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_M_XY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_M_YX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_M_YY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_M_TX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_M_TY = 3'd5;

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // corner emitted at each vertex position: TL, TR, BL, TR, BL, BR
   // corner bit 0 selects right, bit 1 selects bottom
   function automatic logic [1:0] corner_of(input logic [2:0] vidx);
      logic [1:0] k;
      case (vidx)
         3'd0:    k = 2'd0;
         3'd1:    k = 2'd1;
         3'd2:    k = 2'd2;
         3'd3:    k = 2'd1;
         3'd4:    k = 2'd2;
         3'd5:    k = 2'd3;
         default: k = 2'd0;
      endcase
      return k;
   endfunction

endpackage

>>> hdl/tqbs_div.sv
// Radix-16 restoring divider for saturated 0.16 texture coordinates.
`timescale 1ns / 1ps
module tqbs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tqbs_pkg::UV_W:0]      num,
   input  logic [tqbs_pkg::UV_W-1:0]    den,
   output logic                         done,
   output logic [tqbs_pkg::UV_W-1:0]    quot
);
   import tqbs_pkg::*;

   localparam int BITS_PER_STEP = 4;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [UV_W-1:0]      rem_ff, rem_in;
   logic [UV_W-1:0]      den_ff, den_in;
   logic [UV_W-1:0]      q_ff, q_in;

   always_comb begin
      logic [UV_W:0]   r;
      logic [UV_W-1:0] q;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      r       = {1'b0, rem_ff};
      q       = q_ff;
      if (start) begin
         den_in = den;
         if (den == '0 || num >= {1'b0, den}) begin
            // quotient would not fit in 0.16: saturate
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = num[UV_W-1:0];
            q_in    = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < BITS_PER_STEP; i++) begin
            r = {r[UV_W-1:0], 1'b0};
            if (r >= {1'b0, den_ff}) begin
               r = r - {1'b0, den_ff};
               q = {q[UV_W-2:0], 1'b1};
            end else begin
               q = {q[UV_W-2:0], 1'b0};
            end
         end
         rem_in = r[UV_W-1:0];
         q_in   = q;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> hdl/tqbs_mac.sv
// Shared multiplier and accumulator: one affine row a*x + b*y, >>16, + t.
`timescale 1ns / 1ps
module tqbs_mac (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] coef_a,
   input  logic signed [31:0] coef_b,
   input  logic signed [31:0] pt_x,
   input  logic signed [31:0] pt_y,
   input  logic        [31:0] trans,
   output logic               done,
   output logic        [31:0] result
);
   import tqbs_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_SEC  = 2'd1;
   localparam logic [1:0] PH_ACC  = 2'd2;
   localparam logic [1:0] PH_OUT  = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [47:0]        acc_ff, acc_in;
   logic [31:0]        res_ff, res_in;
   logic               done_ff, done_in;
   logic signed [31:0] mul_a, mul_b;

   // only bits 47..16 of the sum reach the result, so 48 bits suffice
   assign mul_a   = (phase_ff == PH_SEC) ? coef_b : coef_a;
   assign mul_b   = (phase_ff == PH_SEC) ? pt_y : pt_x;
   assign prod_in = mul_a * mul_b;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (phase_ff)
         PH_IDLE: if (start) phase_in = PH_SEC;
         PH_SEC: begin
            acc_in   = prod_ff[47:0];
            phase_in = PH_ACC;
         end
         PH_ACC: begin
            acc_in   = acc_ff + prod_ff[47:0];
            phase_in = PH_OUT;
         end
         PH_OUT: begin
            res_in   = acc_ff[47:16] + trans;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> hdl/textured_quad_batch_setup_core.sv
// Top level: batch bookkeeping, slot search and the sequencer around the shared units.
`timescale 1ns / 1ps
// Textured quad batch setup.
// req_* carries one item per quad draw (kind 0) or batch flush (kind 1); rsp_*
// returns vertex and flush-marker items, rsp_last marking an item's final result.
// csr_* writes the six Q16.16 matrix registers; write only while idle.
// A quad walks the used texture slots one per cycle, may emit a flush marker,
// then runs four UV divisions on one radix-16 divider and eight affine rows on
// one 32x32 multiplier, then emits six vertices, one per cycle while rsp_stall
// is low. A flush emits one marker, or nothing when the batch is empty.
// req_stall is high from acceptance until the item's last result is loaded
// into the output register; the output register holds a result while the
// receiver stalls and the sequencer waits on it.
// Reset (synchronous, active high) empties the batch, restores the identity
// matrix and drops any pending result. Slot ids need no reset: only slots
// below the used count are ever compared.
module textured_quad_batch_setup_core #(
   parameter int SLOTS           = tqbs_pkg::SLOTS_DEF,
   parameter int VERTEX_CAPACITY = tqbs_pkg::VCAP_DEF,
   localparam int VCW = $clog2(VERTEX_CAPACITY + 1),
   localparam int SUW = $clog2(SLOTS + 1),
   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [31:0]                      req_texture_id,
   input  logic [15:0]                      req_tex_width,
   input  logic [15:0]                      req_tex_height,
   input  logic [31:0]                      req_src_origin,
   input  logic [31:0]                      req_src_size,
   input  logic signed [31:0]               req_dst_x,
   input  logic signed [31:0]               req_dst_y,
   input  logic signed [31:0]               req_dst_w,
   input  logic signed [31:0]               req_dst_h,
   input  logic [31:0]                      req_rgba,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_flush,
   output logic [VCW-1:0]                   rsp_flushed_vertices,
   output logic [SUW-1:0]                   rsp_flushed_slots,
   output logic signed [31:0]               rsp_pos_x,
   output logic signed [31:0]               rsp_pos_y,
   output logic [15:0]                      rsp_tex_u,
   output logic [15:0]                      rsp_tex_v,
   output logic [31:0]                      rsp_vertex_rgba,
   output logic [SW-1:0]                    rsp_slot,
   output logic                             rsp_last,
   input  logic                             csr_write,
   input  logic [tqbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import tqbs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_FLUSH  = 4'd3;
   localparam logic [3:0] S_CLAIM  = 4'd4;
   localparam logic [3:0] S_DIVST  = 4'd5;
   localparam logic [3:0] S_DIVWT  = 4'd6;
   localparam logic [3:0] S_MACST  = 4'd7;
   localparam logic [3:0] S_MACWT  = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   localparam logic [VCW:0] CAP_L   = (VCW + 1)'(VERTEX_CAPACITY);
   localparam logic [VCW:0] QUAD_L  = (VCW + 1)'(VERTS_PER_QUAD);
   localparam logic [SUW-1:0] SLOTS_L = SUW'(SLOTS);
   localparam logic [SUW-1:0] ONE_SU  = SUW'(1);
   localparam logic [2:0] LAST_VTX = 3'(VERTS_PER_QUAD - 1);

   // matrix
   logic signed [31:0] m_xx_ff, m_xy_ff, m_yx_ff, m_yy_ff, m_tx_ff, m_ty_ff;

   // batch state
   logic [31:0]    slot_ids_ff [SLOTS];
   logic [SUW-1:0] used_ff, used_in;
   logic [VCW-1:0] count_ff, count_in;

   // sequencer
   logic [3:0]     state_ff, state_in;
   logic [SUW-1:0] idx_ff, idx_in;
   logic           found_ff, found_in;
   logic [SW-1:0]  sl_ff, sl_in;
   logic [1:0]     dsel_ff, dsel_in;
   logic [2:0]     op_ff, op_in;
   logic [2:0]     vidx_ff, vidx_in;
   logic           slot_we;

   // latched item
   logic        kind_ff;
   logic [31:0] id_ff, rgba_ff, org_ff, size_ff;
   logic [15:0] tw_ff, th_ff;
   logic [31:0] xl_ff, yt_ff, dw_ff, dh_ff, xr_ff, yb_ff;
   logic        capture;

   logic [15:0] uv_ff [4];
   logic [31:0] px_ff [4];
   logic [31:0] py_ff [4];

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic           o_flush_ff, o_last_ff;
   logic [VCW-1:0] o_fv_ff;
   logic [SUW-1:0] o_fs_ff;
   logic [31:0]    o_px_ff, o_py_ff, o_rgba_ff;
   logic [15:0]    o_u_ff, o_v_ff;
   logic [SW-1:0]  o_slot_ff;
   logic           out_free, load_flush, load_vtx;

   // shared units
   logic              div_start, div_done;
   logic [UV_W:0]     div_num;
   logic [UV_W-1:0]   div_den, div_q;
   logic              mac_start, mac_done;
   logic signed [31:0] mac_a, mac_b, mac_x, mac_y;
   logic [31:0]       mac_t, mac_res;
   logic [1:0]        corner;
   logic [1:0]        vcorner;

   logic cap_full;
   assign cap_full  = ({1'b0, count_ff} + QUAD_L) > CAP_L;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign capture   = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      sl_in      = sl_ff;
      dsel_in    = dsel_ff;
      op_in      = op_ff;
      vidx_in    = vidx_ff;
      used_in    = used_ff;
      count_in   = count_ff;
      slot_we    = 1'b0;
      load_flush = 1'b0;
      load_vtx   = 1'b0;
      div_start  = 1'b0;
      mac_start  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (capture) begin
               if (req_kind) begin
                  if (count_ff != '0) state_in = S_FLUSH;
               end else begin
                  idx_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (idx_ff == used_ff) begin
               state_in = S_DECIDE;
            end else if (slot_ids_ff[idx_ff[SW-1:0]] == id_ff) begin
               found_in = 1'b1;
               sl_in    = idx_ff[SW-1:0];
               state_in = S_DECIDE;
            end else begin
               idx_in = idx_ff + ONE_SU;
            end
         end
         S_DECIDE: begin
            state_in = S_CLAIM;
            if (cap_full || (!found_ff && used_ff >= SLOTS_L)) begin
               // batch cannot take this quad: start over, texture counts as new
               found_in = 1'b0;
               if (count_ff != '0) begin
                  state_in = S_FLUSH;
               end else begin
                  used_in = '0;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               load_flush = 1'b1;
               count_in   = '0;
               used_in    = '0;
               state_in   = kind_ff ? S_IDLE : S_CLAIM;
            end
         end
         S_CLAIM: begin
            if (!found_ff) begin
               slot_we = 1'b1;
               sl_in   = used_ff[SW-1:0];
               used_in = used_ff + ONE_SU;
            end
            count_in = count_ff + VCW'(VERTS_PER_QUAD);
            dsel_in  = '0;
            state_in = S_DIVST;
         end
         S_DIVST: begin
            div_start = 1'b1;
            state_in  = S_DIVWT;
         end
         S_DIVWT: begin
            if (div_done) begin
               dsel_in = dsel_ff + 2'd1;
               if (dsel_ff == 2'd3) begin
                  op_in    = '0;
                  state_in = S_MACST;
               end else begin
                  state_in = S_DIVST;
               end
            end
         end
         S_MACST: begin
            mac_start = 1'b1;
            state_in  = S_MACWT;
         end
         S_MACWT: begin
            if (mac_done) begin
               op_in = op_ff + 3'd1;
               if (op_ff == 3'd7) begin
                  vidx_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_MACST;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               load_vtx = 1'b1;
               vidx_in  = vidx_ff + 3'd1;
               if (vidx_ff == LAST_VTX) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // divider operands: u0, u1, v0, v1
   always_comb begin
      case (dsel_ff)
         2'd0:    div_num = {1'b0, org_ff[31:16]};
         2'd1:    div_num = {1'b0, org_ff[31:16]} + {1'b0, size_ff[31:16]};
         2'd2:    div_num = {1'b0, org_ff[15:0]};
         2'd3:    div_num = {1'b0, org_ff[15:0]} + {1'b0, size_ff[15:0]};
         default: div_num = '0;
      endcase
      div_den = dsel_ff[1] ? th_ff : tw_ff;
   end

   // affine operands: op = {corner, axis}
   assign corner = op_ff[2:1];
   assign mac_a  = op_ff[0] ? m_yx_ff : m_xx_ff;
   assign mac_b  = op_ff[0] ? m_yy_ff : m_xy_ff;
   assign mac_t  = op_ff[0] ? m_ty_ff : m_tx_ff;
   assign mac_x  = corner[0] ? xr_ff : xl_ff;
   assign mac_y  = corner[1] ? yb_ff : yt_ff;

   assign vcorner = corner_of(vidx_ff);

   tqbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   tqbs_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .coef_a (mac_a),
      .coef_b (mac_b),
      .pt_x   (mac_x),
      .pt_y   (mac_y),
      .trans  (mac_t),
      .done   (mac_done),
      .result (mac_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_flush || load_vtx) rsp_valid_in = 1'b1;
      else if (!rsp_stall)        rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         m_xx_ff      <= ONE_Q16;
         m_xy_ff      <= '0;
         m_yx_ff      <= '0;
         m_yy_ff      <= ONE_Q16;
         m_tx_ff      <= '0;
         m_ty_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               REG_M_XX: m_xx_ff <= csr_wdata;
               REG_M_XY: m_xy_ff <= csr_wdata;
               REG_M_YX: m_yx_ff <= csr_wdata;
               REG_M_YY: m_yy_ff <= csr_wdata;
               REG_M_TX: m_tx_ff <= csr_wdata;
               REG_M_TY: m_ty_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      found_ff <= found_in;
      sl_ff    <= sl_in;
      dsel_ff  <= dsel_in;
      op_ff    <= op_in;
      vidx_ff  <= vidx_in;
      if (slot_we) slot_ids_ff[used_ff[SW-1:0]] <= id_ff;
      if (capture) begin
         kind_ff <= req_kind;
         id_ff   <= req_texture_id;
         tw_ff   <= req_tex_width;
         th_ff   <= req_tex_height;
         org_ff  <= req_src_origin;
         size_ff <= req_src_size;
         xl_ff   <= req_dst_x;
         yt_ff   <= req_dst_y;
         dw_ff   <= req_dst_w;
         dh_ff   <= req_dst_h;
         rgba_ff <= req_rgba;
      end
      if (state_ff == S_CLAIM) begin
         xr_ff <= xl_ff + dw_ff;
         yb_ff <= yt_ff + dh_ff;
      end
      if (state_ff == S_DIVWT && div_done) uv_ff[dsel_ff] <= div_q;
      if (state_ff == S_MACWT && mac_done) begin
         if (op_ff[0]) py_ff[corner] <= mac_res;
         else          px_ff[corner] <= mac_res;
      end
      if (load_flush) begin
         o_flush_ff <= 1'b1;
         o_fv_ff    <= count_ff;
         o_fs_ff    <= used_ff;
         o_px_ff    <= '0;
         o_py_ff    <= '0;
         o_u_ff     <= '0;
         o_v_ff     <= '0;
         o_rgba_ff  <= '0;
         o_slot_ff  <= '0;
         o_last_ff  <= kind_ff;
      end else if (load_vtx) begin
         o_flush_ff <= 1'b0;
         o_fv_ff    <= '0;
         o_fs_ff    <= '0;
         o_px_ff    <= px_ff[vcorner];
         o_py_ff    <= py_ff[vcorner];
         o_u_ff     <= uv_ff[{1'b0, vcorner[0]}];
         o_v_ff     <= uv_ff[{1'b1, vcorner[1]}];
         o_rgba_ff  <= rgba_ff;
         o_slot_ff  <= sl_ff;
         o_last_ff  <= (vidx_ff == LAST_VTX);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_flush         = o_flush_ff;
   assign rsp_flushed_vertices = o_fv_ff;
   assign rsp_flushed_slots    = o_fs_ff;
   assign rsp_pos_x            = o_px_ff;
   assign rsp_pos_y            = o_py_ff;
   assign rsp_tex_u            = o_u_ff;
   assign rsp_tex_v            = o_v_ff;
   assign rsp_vertex_rgba      = o_rgba_ff;
   assign rsp_slot             = o_slot_ff;
   assign rsp_last             = o_last_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOTS_L)
      else $error("slot count beyond table size");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= CAP_L)
      else $error("vertex count beyond capacity");

   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      load_flush |-> count_ff != '0 && used_ff != '0)
      else $error("flush marker for an empty batch");

   a_vertex_slot: assert property (@(posedge clock) disable iff (reset)
      load_vtx |-> {1'b0, sl_ff} < {1'b0, used_ff})
      else $error("vertex samples an unclaimed slot");

endmodule
